/* design/mtswd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtswd_pkg
// Shared types and codes for the multi-task software watchdog.
// ----------------------------------------------------------------------------
package mtswd_pkg;

	localparam logic [1:0] FUNC_REGISTER   = 2'd0;
	localparam logic [1:0] FUNC_SIGN       = 2'd1;
	localparam logic [1:0] FUNC_UNREGISTER = 2'd2;
	localparam logic [1:0] FUNC_TICK       = 2'd3;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_DUP     = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;
	localparam logic [1:0] STATUS_BADSLOT = 2'd3;

	// register index as seen on the APB port (paddr[2])
	localparam logic REG_RELOAD = 1'b0;
	localparam logic REG_TPP    = 1'b1;

	localparam logic [3:0]  RELOAD_RST = 4'd5;
	localparam logic [15:0] TPP_RST    = 16'd60;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] task_id;
		logic [3:0]  slot;
	} req_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] slot_out;
		logic [4:0] expired_count;
		logic       reset_request;
		logic       feed_pulse;
	} rsp_word_t;

endpackage
`default_nettype wire

/* design/multi_task_software_watchdog_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// multi_task_software_watchdog_core
// Table of task watchdog slots with register/sign/unregister/tick commands.
// ----------------------------------------------------------------------------
// Unregister, bad slot and a tick that does not end a period go straight to
// the finish state; sign reads and then updates its slot; register and a tick
// ending a period walk the table (one slot memory read per cycle, one read port).
// One word at a time: req_stall stays high until the result is registered.
// Reset clears all slot valid bits and the tick prescaler and loads the
// registers with 5 and 60; no clearing pass, slot memories are left as is.
module multi_task_software_watchdog_core #(
	parameter int SLOTS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire mtswd_pkg::req_word_t  req,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output mtswd_pkg::rsp_word_t       rsp,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [2:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import mtswd_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int EW = $clog2(SLOTS + 1);
	localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SCAN    = 3'd1;
	localparam logic [2:0] ST_SIGN_RD = 3'd2;
	localparam logic [2:0] ST_SIGN_WR = 3'd3;
	localparam logic [2:0] ST_TICK    = 3'd4;
	localparam logic [2:0] ST_FIN     = 3'd5;

	// configuration
	logic [3:0]  reload_q;
	logic [15:0] tpp_q;

	// control
	logic [2:0]      state_q;
	logic [SLOTS-1:0] valid_q;
	logic [15:0]     prescale_q;
	logic [SW-1:0]   idx_q;
	logic            iss_q;
	logic            vld_s1;
	logic [SW-1:0]   idx_s1;

	// per-command work registers
	logic [15:0]   task_q;
	logic [SW-1:0] slot_q;
	logic          dup_q;
	logic          found_q;
	logic [SW-1:0] free_q;
	logic [EW-1:0] exp_q;
	rsp_word_t     res_q;
	rsp_word_t     out_q;
	logic          out_valid_q;

	// slot memories
	logic [15:0] task_mem [SLOTS];
	logic [4:0]  cnt_mem  [SLOTS];
	logic [15:0] rd_task_q;
	logic [4:0]  rd_cnt_q;
	logic [SW-1:0] rd_addr;

	logic          task_we;
	logic [SW-1:0] task_wa;
	logic          cnt_we;
	logic [SW-1:0] cnt_wa;
	logic [4:0]    cnt_wd;

	// decode
	logic          accept;
	logic [8:0]    slot_w;
	logic [SW-1:0] slot_idx;
	logic          slot_live;
	logic [16:0]   pre_inc;
	logic          period_end;
	logic          cfg_wr;

	// walk datapath
	logic          v_cur;
	logic          walk_last;
	logic          dup_n;
	logic          found_n;
	logic [SW-1:0] free_n;
	logic [4:0]    dec_cnt;
	logic          hit;
	logic [EW-1:0] exp_n;
	logic [8:0]    free_w;
	logic [8:0]    exp_w;
	logic          out_free;

	assign accept     = req_valid && !req_stall;
	assign req_stall  = (state_q != ST_IDLE);
	assign slot_w     = 9'(req.slot);
	assign slot_idx   = slot_w[SW-1:0];
	assign slot_live  = (slot_w < 9'(SLOTS)) && valid_q[slot_idx];
	assign pre_inc    = {1'b0, prescale_q} + 17'd1;
	assign period_end = (pre_inc >= {1'b0, tpp_q});
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign out_free   = !out_valid_q || !rsp_stall;

	assign v_cur     = valid_q[idx_s1];
	assign walk_last = vld_s1 && (idx_s1 == LAST);
	assign dup_n     = dup_q || (v_cur && (rd_task_q == task_q));
	assign found_n   = found_q || !v_cur;
	assign free_n    = (!found_q && !v_cur) ? idx_s1 : free_q;
	assign dec_cnt   = rd_cnt_q[4] ? rd_cnt_q : (rd_cnt_q - 5'd1);
	assign hit       = v_cur && (dec_cnt == 5'd0);
	assign exp_n     = exp_q + EW'(hit);
	assign free_w    = 9'(free_n);
	assign exp_w     = 9'(exp_n);

	assign rd_addr = (state_q == ST_SIGN_RD) ? slot_q : idx_q;

	always_comb begin
		task_we = 1'b0;
		task_wa = free_n;
		cnt_we  = 1'b0;
		cnt_wa  = idx_s1;
		cnt_wd  = dec_cnt;
		case (state_q)
			ST_SCAN: begin
				if (walk_last && !dup_n && found_n) begin
					task_we = 1'b1;
					cnt_we  = 1'b1;
					cnt_wa  = free_n;
					cnt_wd  = {1'b0, reload_q};
				end
			end
			ST_SIGN_WR: begin
				cnt_wa = slot_q;
				cnt_wd = {1'b0, reload_q};
				cnt_we = !rd_cnt_q[4] && (rd_cnt_q != 5'd0);
			end
			ST_TICK: begin
				cnt_we = vld_s1 && v_cur;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (task_we) begin
			task_mem[task_wa] <= task_q;
		end
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		rd_task_q <= task_mem[rd_addr];
		rd_cnt_q  <= cnt_mem[rd_addr];
	end

	// APB registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= RELOAD_RST;
			tpp_q    <= TPP_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_RELOAD: reload_q <= pwdata[3:0];
				REG_TPP:    tpp_q    <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_RELOAD: prdata = {28'd0, reload_q};
			REG_TPP:    prdata = {16'd0, tpp_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign pready = 1'b1;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			prescale_q  <= '0;
			idx_q       <= '0;
			iss_q       <= 1'b0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= iss_q;
			idx_s1 <= idx_q;
			if (iss_q) begin
				idx_q <= idx_q + SW'(1);
				if (idx_q == LAST) begin
					iss_q <= 1'b0;
				end
			end
			if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_FIN;
						case (req.func)
							FUNC_REGISTER: begin
								state_q <= ST_SCAN;
								idx_q   <= '0;
								iss_q   <= 1'b1;
							end
							FUNC_SIGN: begin
								if (slot_live) begin
									state_q <= ST_SIGN_RD;
								end
							end
							FUNC_UNREGISTER: begin
								if (slot_live) begin
									valid_q[slot_idx] <= 1'b0;
								end
							end
							default: begin
								if (period_end) begin
									prescale_q <= '0;
									state_q    <= ST_TICK;
									idx_q      <= '0;
									iss_q      <= 1'b1;
								end else begin
									prescale_q <= pre_inc[15:0];
								end
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (walk_last) begin
						if (!dup_n && found_n) begin
							valid_q[free_n] <= 1'b1;
						end
						state_q <= ST_FIN;
					end
				end
				ST_SIGN_RD: begin
					state_q <= ST_SIGN_WR;
				end
				ST_SIGN_WR: begin
					state_q <= ST_FIN;
				end
				ST_TICK: begin
					if (walk_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// work registers and result assembly
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_q <= res_q;
		end
		case (state_q)
			ST_IDLE: begin
				task_q  <= req.task_id;
				slot_q  <= slot_idx;
				dup_q   <= 1'b0;
				found_q <= 1'b0;
				free_q  <= '0;
				exp_q   <= '0;
				res_q   <= '0;
				case (req.func)
					FUNC_SIGN, FUNC_UNREGISTER: begin
						res_q.status <= slot_live ? STATUS_OK : STATUS_BADSLOT;
					end
					FUNC_TICK: begin
						res_q.feed_pulse <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			ST_SCAN: begin
				if (vld_s1) begin
					dup_q   <= dup_n;
					found_q <= found_n;
					free_q  <= free_n;
				end
				if (walk_last) begin
					if (dup_n) begin
						res_q.status <= STATUS_DUP;
					end else if (!found_n) begin
						res_q.status <= STATUS_FULL;
					end else begin
						res_q.slot_out <= free_w[3:0];
					end
				end
			end
			ST_TICK: begin
				if (vld_s1) begin
					exp_q <= exp_n;
				end
				if (walk_last) begin
					res_q.expired_count <= exp_w[4:0];
					res_q.reset_request <= (exp_n != '0);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// a result word only appears after the sequencer has finished
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_FIN))
		else $error("result raised outside finish state");

	// the read pipeline only runs during a table walk
	a_walk_only: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_SCAN || state_q == ST_TICK))
		else $error("walk pipeline active outside a walk");

	// expiry is only reported on ticks
	a_expiry_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.feed_pulse) |-> (rsp.expired_count == 5'd0 && !rsp.reset_request))
		else $error("expiry reported on a non-tick word");

	// only a successful register reports a slot
	a_slot_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != STATUS_OK) |-> (rsp.slot_out == 4'd0))
		else $error("slot reported with an error status");

endmodule
`default_nettype wire

/* test/multi_task_software_watchdog_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_task_software_watchdog_core_test
// Self-checking bench for the task watchdog table. A clocked driver offers
// request words from a queue and a clocked monitor checks every response word
// against a cycle-free model of the slot table. The run covers register,
// sign, unregister and tick words under several reload/period settings and
// several idle and stall patterns.
// ----------------------------------------------------------------------------
module multi_task_software_watchdog_core_test;
	import mtswd_pkg::*;

	localparam int SLOTS       = 16;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 203;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_word_t   req       = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_word_t   rsp;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	multi_task_software_watchdog_core #(.SLOTS(SLOTS)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// slot table as the block should hold it
	logic              tbl_valid [SLOTS];
	logic [15:0]       tbl_task [SLOTS];
	logic signed [4:0] tbl_count [SLOTS];
	logic [15:0]       tbl_prescale;
	logic [3:0]        cfg_reload = RELOAD_RST;
	logic [15:0]       cfg_period = TPP_RST;

	req_word_t   pending_words [$];
	rsp_word_t   awaited_results [$];
	logic [15:0] task_pool [24];

	int   send_idle_pct = 0;
	int   stall_pct     = 0;
	logic long_hold_arm  = 1'b0;
	logic long_hold_done = 1'b0;
	int   hold_left      = 0;
	int   quiet_cycles   = 0;
	int   errors         = 0;

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_task[i]  = '0;
			tbl_count[i] = '0;
		end
		tbl_prescale = '0;
	end

	function automatic rsp_word_t watchdog_step(req_word_t w);
		rsp_word_t r;
		int        free_idx;
		logic      dup;
		int        expired;
		r = '0;
		expired = 0;
		case (w.func)
			FUNC_REGISTER: begin
				dup = 1'b0;
				free_idx = -1;
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_valid[i]) begin
						if (tbl_task[i] == w.task_id)
							dup = 1'b1;
					end else if (free_idx < 0) begin
						free_idx = i;
					end
				end
				if (dup)
					r.status = STATUS_DUP;
				else if (free_idx < 0)
					r.status = STATUS_FULL;
				else begin
					tbl_valid[free_idx] = 1'b1;
					tbl_task[free_idx]  = w.task_id;
					tbl_count[free_idx] = $signed({1'b0, cfg_reload});
					r.slot_out = 4'(free_idx);
				end
			end
			FUNC_SIGN: begin
				if (!tbl_valid[w.slot])
					r.status = STATUS_BADSLOT;
				else if (tbl_count[w.slot] > 0)
					tbl_count[w.slot] = $signed({1'b0, cfg_reload});
			end
			FUNC_UNREGISTER: begin
				if (!tbl_valid[w.slot])
					r.status = STATUS_BADSLOT;
				else
					tbl_valid[w.slot] = 1'b0;
			end
			default: begin
				r.feed_pulse = 1'b1;
				// period ends also when the period was shrunk below the prescaler
				if ({1'b0, tbl_prescale} + 17'd1 >= {1'b0, cfg_period}) begin
					tbl_prescale = '0;
					for (int i = 0; i < SLOTS; i++) begin
						if (tbl_valid[i]) begin
							if (tbl_count[i] >= 0)
								tbl_count[i] = tbl_count[i] - 5'sd1;
							if (tbl_count[i] == 0)
								expired++;
						end
					end
				end else begin
					tbl_prescale = tbl_prescale + 16'd1;
				end
			end
		endcase
		r.expired_count = 5'(expired);
		r.reset_request = (expired != 0);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver: one word offered at a time, held while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				awaited_results.push_back(watchdog_step(req));
			if (!req_valid || !req_stall) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req <= pending_words.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random stall plus one long hold-off
	always @(posedge clk) begin
		rsp_word_t want;
		if (rsp_valid && !rsp_stall) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("word with nothing pending", int'(rsp), 0);
			end else begin
				want = awaited_results.pop_front();
				if (rsp.status != want.status)
					report_mismatch("status", int'(rsp.status), int'(want.status));
				if (rsp.slot_out != want.slot_out)
					report_mismatch("slot_out", int'(rsp.slot_out), int'(want.slot_out));
				if (rsp.expired_count != want.expired_count)
					report_mismatch("expired_count", int'(rsp.expired_count),
						int'(want.expired_count));
				if (rsp.reset_request != want.reset_request)
					report_mismatch("reset_request", int'(rsp.reset_request),
						int'(want.reset_request));
				if (rsp.feed_pulse != want.feed_pulse)
					report_mismatch("feed_pulse", int'(rsp.feed_pulse), int'(want.feed_pulse));
			end
		end
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (long_hold_arm && !long_hold_done) begin
			hold_left <= HOLD_CYCLES;
			long_hold_done <= 1'b1;
		end
		rsp_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("multi_task_software_watchdog_core_test failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic apb_write(input logic reg_sel, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_sel == REG_RELOAD)
			cfg_reload = value[3:0];
		else
			cfg_period = value[15:0];
	endtask

	task automatic wait_for_quiet();
		while (pending_words.size() != 0 || req_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic push_word(input logic [1:0] f, input logic [15:0] id, input logic [3:0] s);
		req_word_t w;
		w.func    = f;
		w.task_id = id;
		w.slot    = s;
		pending_words.push_back(w);
	endtask

	// mostly pooled task ids so duplicates and a full table come up often
	function automatic req_word_t random_word();
		req_word_t w;
		int        pick;
		pick = $urandom_range(99);
		if (pick < 30)
			w.func = FUNC_REGISTER;
		else if (pick < 62)
			w.func = FUNC_SIGN;
		else if (pick < 78)
			w.func = FUNC_UNREGISTER;
		else
			w.func = FUNC_TICK;
		if ($urandom_range(9) < 7)
			w.task_id = task_pool[$urandom_range(23)];
		else
			w.task_id = 16'($urandom_range(65535));
		w.slot = 4'($urandom_range(15));
		return w;
	endfunction

	initial begin
		logic [3:0]  reloads [PHASES];
		logic [15:0] periods [PHASES];
		int          send_pct [4];
		int          recv_pct [4];
		reloads = '{4'd3, 4'd15, 4'd0, 4'd1, 4'd10, 4'd2, 4'd5, 4'd4};
		periods = '{16'd2, 16'd0, 16'd1, 16'd65535, 16'd1, 16'd3, 16'd60, 16'd0};
		send_pct = '{0, 79, 0, 22};
		recv_pct = '{0, 0, 79, 22};
		for (int i = 0; i < 24; i++)
			task_pool[i] = 16'($urandom_range(65535));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every tick ends a period, one period per reload
		apb_write(REG_RELOAD, 32'd1);
		apb_write(REG_TPP, 32'd0);
		push_word(FUNC_SIGN, 16'h0000, 4'd0);
		push_word(FUNC_UNREGISTER, 16'hFFFF, 4'd15);
		push_word(FUNC_REGISTER, 16'hFFFF, 4'd15);
		push_word(FUNC_REGISTER, 16'hFFFF, 4'd0);
		push_word(FUNC_REGISTER, 16'h0000, 4'd0);
		push_word(FUNC_SIGN, 16'h1111, 4'd1);
		push_word(FUNC_TICK, 16'hFFFF, 4'd15);
		// signing an expired slot is accepted but does not reload it
		push_word(FUNC_SIGN, 16'h0000, 4'd0);
		push_word(FUNC_TICK, 16'h0000, 4'd0);
		push_word(FUNC_TICK, 16'h0000, 4'd0);
		push_word(FUNC_UNREGISTER, 16'h0000, 4'd0);
		push_word(FUNC_UNREGISTER, 16'h0000, 4'd0);
		for (int i = 0; i < SLOTS - 1; i++)
			push_word(FUNC_REGISTER, 16'(16'h5A00 + i), 4'(i));
		push_word(FUNC_REGISTER, 16'h1234, 4'd7);
		push_word(FUNC_SIGN, 16'h0000, 4'd15);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_for_quiet();
			apb_write(REG_RELOAD, 32'(reloads[ph]));
			apb_write(REG_TPP, 32'(periods[ph]));
			send_idle_pct = send_pct[ph % 4];
			stall_pct     = recv_pct[ph % 4];
			if (ph == 4)
				long_hold_arm = 1'b1;
			for (int n = 0; n < PHASE_WORDS; n++)
				pending_words.push_back(random_word());
		end

		while (pending_words.size() != 0 || req_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (awaited_results.size() != 0)
			report_mismatch("words never returned", 0, awaited_results.size());
		if (errors == 0)
			$display("multi_task_software_watchdog_core_test passed");
		else
			$display("multi_task_software_watchdog_core_test failed");
		$finish;
	end

endmodule

/* sim.f */
design/mtswd_pkg.sv
design/multi_task_software_watchdog_core.sv
test/multi_task_software_watchdog_core_test.sv
